// ===== sv/imm_alu_pkg.sv =====
package imm_alu_pkg;

    localparam int DataWidth = 64;
    localparam int MagWidth  = DataWidth;

    typedef logic signed [DataWidth-1:0] data_t;
    typedef logic [MagWidth-1:0]         mag_t;

    typedef enum logic [2:0] {
        CMD_IDENTITY = 3'd0,
        CMD_ABS      = 3'd1,
        CMD_SIGN     = 3'd2,
        CMD_MIN      = 3'd3,
        CMD_MAX      = 3'd4,
        CMD_CLAMP    = 3'd5,
        CMD_POSMOD   = 3'd6,
        CMD_WRAP     = 3'd7
    } cmd_t;

    // work carried down the remainder chain
    typedef struct packed {
        logic  valid;
        logic  err;
        logic  use_rem;   // final value comes from the remainder chain
        logic  pass2;     // wrap needs a second remainder
        logic  is_wrap;   // wrap adds the lower bound, no divisor-sign adjust
        logic  neg_x;     // dividend sign of the current remainder
        logic  neg_y;     // divisor sign
        data_t y;         // signed divisor
        data_t base;      // value to add at the end (lower bound for wrap)
        data_t direct;    // result when no remainder is used
        mag_t  rem;       // partial remainder
        mag_t  dvd;       // remaining dividend bits, msb first
        mag_t  dvs;       // divisor magnitude
    } cell_t;

    function automatic mag_t mag_of(input data_t v);
        mag_of = v[DataWidth-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

endpackage

// ===== sv/imm_alu_front.sv =====
module imm_alu_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [2:0]           command,
    input  imm_alu_pkg::data_t   operand_a,
    input  imm_alu_pkg::data_t   operand_b,
    input  imm_alu_pkg::data_t   operand_c,
    input  logic [1:0]           operand_count,
    output imm_alu_pkg::cell_t   cell_out
);
    import imm_alu_pkg::*;

    cell_t cell_reg, cell_next;
    data_t diff, range;
    logic [1:0] need;

    always_comb
    begin
        cell_next = '0;
        diff  = operand_a - operand_b;
        range = operand_c - operand_b;
        case (cmd_t'(command))
            CMD_IDENTITY, CMD_ABS, CMD_SIGN: need = 2'd1;
            CMD_CLAMP, CMD_WRAP:             need = 2'd3;
            default:                         need = 2'd2;
        endcase
        cell_next.valid = in_valid;
        cell_next.err   = operand_count < need;
        case (cmd_t'(command))
            CMD_IDENTITY: cell_next.direct = operand_a;
            CMD_ABS:      cell_next.direct = operand_a[DataWidth-1] ? -operand_a : operand_a;
            CMD_SIGN:     cell_next.direct = operand_a[DataWidth-1] ? '1 :
                                             data_t'(operand_a != '0);
            CMD_MIN:      cell_next.direct = (operand_a < operand_b) ? operand_a : operand_b;
            CMD_MAX:      cell_next.direct = (operand_b < operand_a) ? operand_a : operand_b;
            CMD_CLAMP:    cell_next.direct = (operand_a < operand_b) ? operand_b :
                                             (operand_c < operand_a) ? operand_c : operand_a;
            CMD_POSMOD:
            begin
                cell_next.use_rem = operand_b != '0;
                cell_next.y       = operand_b;
                cell_next.neg_x   = operand_a[DataWidth-1];
                cell_next.dvd     = mag_of(operand_a);
            end
            default:
            begin
                cell_next.direct  = operand_b;
                cell_next.use_rem = range != '0;
                cell_next.pass2   = 1'b1;
                cell_next.is_wrap = 1'b1;
                cell_next.base    = operand_b;
                cell_next.y       = range;
                cell_next.neg_x   = diff[DataWidth-1];
                cell_next.dvd     = mag_of(diff);
            end
        endcase
        cell_next.neg_y = cell_next.y[DataWidth-1];
        cell_next.dvs   = mag_of(cell_next.y);
    end

    // only the valid flag is reset; payload just follows the enable
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== sv/imm_alu_cell.sv =====
// one restoring-division step: shift in a dividend bit, subtract if it fits
module imm_alu_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  imm_alu_pkg::cell_t cell_in,
    output imm_alu_pkg::cell_t cell_out
);
    import imm_alu_pkg::*;

    cell_t cell_reg, cell_next;
    logic [MagWidth:0] trial;

    always_comb
    begin
        cell_next = cell_in;
        trial = {cell_in.rem, cell_in.dvd[MagWidth-1]} - {1'b0, cell_in.dvs};
        cell_next.dvd = {cell_in.dvd[MagWidth-2:0], 1'b0};
        if (!trial[MagWidth])
            cell_next.rem = trial[MagWidth-1:0];
        else
            cell_next.rem = {cell_in.rem[MagWidth-2:0], cell_in.dvd[MagWidth-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== sv/imm_alu_fix.sv =====
// signs the remainder and sets up the second wrap pass
module imm_alu_fix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  imm_alu_pkg::cell_t cell_in,
    output imm_alu_pkg::cell_t cell_out
);
    import imm_alu_pkg::*;

    cell_t cell_reg, cell_next;
    data_t r, t;

    always_comb
    begin
        cell_next = cell_in;
        r = cell_in.neg_x ? -data_t'(cell_in.rem) : data_t'(cell_in.rem);
        t = r + cell_in.y;
        if (cell_in.pass2)
        begin
            // second pass: (r + range) rem range
            cell_next.pass2 = 1'b0;
            cell_next.neg_x = t[DataWidth-1];
            cell_next.dvd   = mag_of(t);
            cell_next.rem   = '0;
        end
        else
        begin
            cell_next.pass2 = 1'b0;
            cell_next.dvd   = '0;
            cell_next.rem   = '0;
            // posmod adjusts toward divisor sign, wrap adds lower bound
            if (!cell_in.is_wrap && r != '0 && (r[DataWidth-1] != cell_in.neg_y))
                cell_next.direct = t;
            else
                cell_next.direct = r + cell_in.base;
            if (!cell_in.use_rem)
                cell_next.direct = cell_in.direct;
            // value is final, later stages pass it through
            cell_next.use_rem = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg.valid <= 1'b0;
        end
        else if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== sv/integer_min_max_clamp_mod_alu.sv =====
// path: front register, first row of remainder cells, first fix stage, second row, second fix stage
// throughput: one beat per cycle; the chain of remainder cells advances as a whole
// and holds only when the output beat is stalled
// the wrap operation takes a remainder in each of the two cell rows (two remainders in series)
// reset: rst_n asynchronous active low clears all valid flags; payload is not reset
module integer_min_max_clamp_mod_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] command, [66:3] operand_a, [130:67] operand_b, [194:131] operand_c,
    // [196:195] operand_count, [199:197] zero
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] value, [64] status, [71:65] zero
    output logic [71:0]  m_axis_tdata
);
    import imm_alu_pkg::*;

    localparam int Cells = MagWidth;

    logic  en;
    cell_t front_c;
    cell_t row1 [Cells+1];
    cell_t mid_c;
    cell_t row2 [Cells+1];
    cell_t fin_c;

    // whole chain moves when the last stage is empty or being drained
    assign en            = !fin_c.valid || m_axis_tready;
    assign s_axis_tready = en;

    imm_alu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .command       (s_axis_tdata[2:0]),
        .operand_a     (data_t'(s_axis_tdata[66:3])),
        .operand_b     (data_t'(s_axis_tdata[130:67])),
        .operand_c     (data_t'(s_axis_tdata[194:131])),
        .operand_count (s_axis_tdata[196:195]),
        .cell_out      (front_c)
    );

    assign row1[0] = front_c;
    assign row2[0] = mid_c;

    for (genvar g = 0; g < Cells; g++)
    begin : g_row
        imm_alu_cell u_cell1 (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (row1[g]),
            .cell_out (row1[g+1])
        );
        imm_alu_cell u_cell2 (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .cell_in  (row2[g]),
            .cell_out (row2[g+1])
        );
    end

    imm_alu_fix u_fix1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cell_in  (row1[Cells]),
        .cell_out (mid_c)
    );

    imm_alu_fix u_fix2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .cell_in  (row2[Cells]),
        .cell_out (fin_c)
    );

    assign m_axis_tvalid = fin_c.valid;
    assign m_axis_tdata  = {7'd0, fin_c.err, fin_c.err ? 64'd0 : 64'(fin_c.direct)};

`ifndef SYNTHESIS
    // a stalled output beat keeps its data
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // ready only drops while an output beat is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // an error beat carries a zero value
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[63:0] == 64'd0)
        else $error("error beat with nonzero value");
`endif

endmodule
